FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge out of reset.
`define MMEUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The condition must never be seen at a sampled edge out of reset.
`define MMEUS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: src/mmeus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmeus_pkg: shared types and constants
// Field widths, register indexes, reset values and the structs passed
// between the encoder unwrap and speed modules.
// ----------------------------------------------------------------------------
package mmeus_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int MIDX_W     = 2;
  localparam int ID_W       = 11;
  localparam int ANGLE_W    = 13;
  localparam int DELTA_W    = 14;
  localparam int TURNS_W    = 16;
  localparam int POS_W      = 30;
  localparam int SPEED_W    = 16;
  localparam int CALIB_W    = 10;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Moving-average window. The averaging divide is a shift, so the depth
  // is a power of two between 1 and 16.
  localparam int AVG_DEPTH = 4;
  localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
  localparam int PTR_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W     = DELTA_W + AVG_SHIFT + 1;
  localparam int AVG_W     = SUM_W - AVG_SHIFT;
  localparam int PROD_W    = AVG_W + GAIN_W + 1;

  // Half of one revolution in encoder counts, and one full revolution.
  localparam int HALF_REV = 4096;
  localparam int FULL_REV = 8192;

  // Reset values of the configuration registers.
  localparam logic [ID_W-1:0]    MOTOR0_ID_RST    = 11'd513;
  localparam logic [ID_W-1:0]    MOTOR1_ID_RST    = 11'd514;
  localparam logic [ID_W-1:0]    MOTOR2_ID_RST    = 11'd515;
  localparam logic [ID_W-1:0]    MOTOR3_ID_RST    = 11'd516;
  localparam logic [CALIB_W-1:0] CALIB_FRAMES_RST = 10'd1000;
  localparam logic [GAIN_W-1:0]  SPEED_GAIN_RST   = 16'd29999;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR0_ID    = 3'd0,
    REG_MOTOR1_ID    = 3'd1,
    REG_MOTOR2_ID    = 3'd2,
    REG_MOTOR3_ID    = 3'd3,
    REG_CALIB_FRAMES = 3'd4,
    REG_SPEED_GAIN   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_MOTORS-1:0][ID_W-1:0] motor_id;
    logic [CALIB_W-1:0]              calib_frames;
    logic [GAIN_W-1:0]               speed_gain;
  } cfg_t;

  // Identifier match and startup status of the word being processed.
  typedef struct packed {
    logic              hit;
    logic [MIDX_W-1:0] idx;
    logic              calib;
    logic [CALIB_W-1:0] count;
  } match_t;

  // Tracking results of the matched motor after this word.
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [TURNS_W-1:0] turns;
    logic signed [POS_W-1:0]   position;
  } track_t;

endpackage

FILE: src/mmeus_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmeus_in_if / mmeus_out_if: valid-ready channels
// Input channel carries one feedback frame, output channel one result word.
// ----------------------------------------------------------------------------
interface mmeus_in_if;
  logic                              valid;
  logic                              ready;
  logic [mmeus_pkg::ID_W-1:0]        frame_id;
  logic [mmeus_pkg::ANGLE_W-1:0]     angle;

  modport source (output valid, frame_id, angle, input ready);
  modport sink   (input valid, frame_id, angle, output ready);
endinterface

interface mmeus_out_if;
  logic                                valid;
  logic                                ready;
  logic                                matched;
  logic [mmeus_pkg::MIDX_W-1:0]        motor_index;
  logic                                calibrating;
  logic signed [mmeus_pkg::DELTA_W-1:0] delta;
  logic signed [mmeus_pkg::TURNS_W-1:0] turns;
  logic signed [mmeus_pkg::POS_W-1:0]   position;
  logic signed [mmeus_pkg::SPEED_W-1:0] speed;

  modport source (output valid, matched, motor_index, calibrating, delta, turns,
                  position, speed, input ready);
  modport sink   (input valid, matched, motor_index, calibrating, delta, turns,
                  position, speed, output ready);
endinterface

FILE: src/mmeus_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmeus_match: identifier match and startup counter
// Finds the lowest motor whose identifier equals the frame identifier and
// advances the saturating startup counter once per processed word.
// ----------------------------------------------------------------------------
module mmeus_match (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  mmeus_pkg::cfg_t            cfg_i,
  input  logic [mmeus_pkg::ID_W-1:0] frame_id_i,
  output mmeus_pkg::match_t          match_o
);

  logic [mmeus_pkg::CALIB_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic                          hit;
  logic [mmeus_pkg::MIDX_W-1:0]  idx;

  // Priority match: scanning downward leaves the lowest matching motor.
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int k = mmeus_pkg::NUM_MOTORS - 1; k >= 0; k--) begin
      if (cfg_i.motor_id[k] == frame_id_i) begin
        hit = 1'b1;
        idx = mmeus_pkg::MIDX_W'(k);
      end
    end
  end

  // Count up while below the calibration length, and clamp to it if the
  // length was lowered under the current count.
  always_comb begin
    cnt_inc = (cnt_q < cfg_i.calib_frames) ? cnt_q + 1'b1 : cnt_q;
    cnt_d   = (cnt_inc >= cfg_i.calib_frames) ? cfg_i.calib_frames : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign match_o.hit   = hit;
  assign match_o.idx   = idx;
  assign match_o.calib = (cnt_d < cfg_i.calib_frames);
  assign match_o.count = cnt_q;

endmodule

FILE: src/mmeus_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmeus_track: per-motor angle unwrap and position
// Holds last angle, offset, turn count, last delta and position for each
// motor, and updates the matched motor in a single read-modify-write.
// ----------------------------------------------------------------------------
module mmeus_track (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  mmeus_pkg::match_t             match_i,
  input  logic [mmeus_pkg::ANGLE_W-1:0] angle_i,
  output mmeus_pkg::track_t             track_o
);

  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::ANGLE_W-1:0] last_q, off_q;
  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::TURNS_W-1:0] turns_q;
  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::DELTA_W-1:0] ldelta_q;
  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::POS_W-1:0]   pos_q;

  logic [mmeus_pkg::ANGLE_W-1:0]       last_d, off_d;
  logic signed [mmeus_pkg::TURNS_W-1:0] turns_d;
  logic signed [mmeus_pkg::DELTA_W-1:0] delta_d, diff;
  logic signed [mmeus_pkg::DELTA_W:0]   diff_wide;
  logic signed [mmeus_pkg::POS_W-1:0]   pos_d;
  logic signed [mmeus_pkg::DELTA_W-1:0] half_rev;
  logic signed [mmeus_pkg::DELTA_W:0]   full_rev;

  assign half_rev = mmeus_pkg::DELTA_W'(mmeus_pkg::HALF_REV);
  assign full_rev = (mmeus_pkg::DELTA_W + 1)'(mmeus_pkg::FULL_REV);

  // Unwrap the angle step across the revolution boundary.
  always_comb begin
    diff      = $signed({1'b0, angle_i}) - $signed({1'b0, last_q[match_i.idx]});
    diff_wide = (mmeus_pkg::DELTA_W + 1)'(diff);
    last_d    = angle_i;
    off_d     = off_q[match_i.idx];
    turns_d   = turns_q[match_i.idx];
    delta_d   = ldelta_q[match_i.idx];
    pos_d     = pos_q[match_i.idx];
    if (match_i.calib) begin
      // Calibration captures the offset and last angle; delta and position hold.
      off_d = angle_i;
    end else begin
      if (diff > half_rev) begin
        turns_d = turns_q[match_i.idx] - 1'b1;
        delta_d = mmeus_pkg::DELTA_W'(diff_wide - full_rev);
      end else if (diff < -half_rev) begin
        turns_d = turns_q[match_i.idx] + 1'b1;
        delta_d = mmeus_pkg::DELTA_W'(diff_wide + full_rev);
      end else begin
        delta_d = diff;
      end
      // turns * 8192 + angle is the concatenation of the two fields.
      pos_d = $signed({turns_d[mmeus_pkg::TURNS_W-1], turns_d, angle_i})
            - $signed({{(mmeus_pkg::POS_W - mmeus_pkg::ANGLE_W){1'b0}},
                       off_q[match_i.idx]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      off_q    <= '0;
      turns_q  <= '0;
      ldelta_q <= '0;
      pos_q    <= '0;
    end else if (en_i && match_i.hit) begin
      last_q[match_i.idx]   <= last_d;
      off_q[match_i.idx]    <= off_d;
      turns_q[match_i.idx]  <= turns_d;
      ldelta_q[match_i.idx] <= delta_d;
      pos_q[match_i.idx]    <= pos_d;
    end
  end

  assign track_o.delta    = delta_d;
  assign track_o.turns    = turns_d;
  assign track_o.position = pos_d;

endmodule

FILE: src/mmeus_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmeus_speed: moving-average speed
// Keeps a delta ring and a running window sum per motor; the average is
// scaled by the Q4.12 gain, truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module mmeus_speed (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                hit_i,
  input  logic [mmeus_pkg::MIDX_W-1:0]        idx_i,
  input  logic signed [mmeus_pkg::DELTA_W-1:0] delta_i,
  input  logic [mmeus_pkg::GAIN_W-1:0]        gain_i,
  output logic signed [mmeus_pkg::SPEED_W-1:0] speed_o
);

  localparam int ScaledW = mmeus_pkg::PROD_W - mmeus_pkg::GAIN_FRAC;

  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::AVG_DEPTH-1:0]
        [mmeus_pkg::DELTA_W-1:0] ring_q;
  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::SUM_W-1:0] sum_q;
  logic [mmeus_pkg::NUM_MOTORS-1:0][mmeus_pkg::PTR_W-1:0] ptr_q;

  logic [mmeus_pkg::PTR_W-1:0]           ptr, ptr_d;
  logic signed [mmeus_pkg::SUM_W-1:0]    sum_d, old_ext, new_ext, bias, sum_adj, avg_full;
  logic signed [mmeus_pkg::AVG_W-1:0]    avg;
  logic signed [mmeus_pkg::GAIN_W:0]     gain_s;
  logic signed [mmeus_pkg::PROD_W-1:0]   prod, prod_bias, prod_adj, scaled_full;
  logic signed [ScaledW-1:0]             scaled;
  logic signed [ScaledW-1:0]             spd_max, spd_min;

  // Slide the window: drop the oldest delta and add the new one.
  always_comb begin
    ptr     = ptr_q[idx_i];
    ptr_d   = (ptr == mmeus_pkg::PTR_W'(mmeus_pkg::AVG_DEPTH - 1)) ? '0 : ptr + 1'b1;
    old_ext = mmeus_pkg::SUM_W'($signed(ring_q[idx_i][ptr]));
    new_ext = mmeus_pkg::SUM_W'(delta_i);
    sum_d   = $signed(sum_q[idx_i]) - old_ext + new_ext;
  end

  // Average with truncation toward zero: bias negative sums before the shift.
  always_comb begin
    bias     = sum_d[mmeus_pkg::SUM_W-1] ? mmeus_pkg::SUM_W'(mmeus_pkg::AVG_DEPTH - 1) : '0;
    sum_adj  = sum_d + bias;
    avg_full = sum_adj >>> mmeus_pkg::AVG_SHIFT;
    avg      = avg_full[mmeus_pkg::AVG_W-1:0];
  end

  // Gain multiply, then drop the fraction bits toward zero and saturate.
  always_comb begin
    gain_s      = $signed({1'b0, gain_i});
    prod        = avg * gain_s;
    prod_bias   = prod[mmeus_pkg::PROD_W-1]
                ? mmeus_pkg::PROD_W'((1 << mmeus_pkg::GAIN_FRAC) - 1) : '0;
    prod_adj    = prod + prod_bias;
    scaled_full = prod_adj >>> mmeus_pkg::GAIN_FRAC;
    scaled      = scaled_full[ScaledW-1:0];
    spd_max     = ScaledW'((1 << (mmeus_pkg::SPEED_W - 1)) - 1);
    spd_min     = -ScaledW'(1 << (mmeus_pkg::SPEED_W - 1));
    if (scaled > spd_max) begin
      speed_o = spd_max[mmeus_pkg::SPEED_W-1:0];
    end else if (scaled < spd_min) begin
      speed_o = spd_min[mmeus_pkg::SPEED_W-1:0];
    end else begin
      speed_o = scaled[mmeus_pkg::SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      sum_q  <= '0;
      ptr_q  <= '0;
    end else if (en_i && hit_i) begin
      ring_q[idx_i][ptr] <= delta_i;
      sum_q[idx_i]       <= sum_d;
      ptr_q[idx_i]       <= ptr_d;
    end
  end

endmodule

FILE: src/multi_motor_encoder_unwrap_speed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_motor_encoder_unwrap_speed: four-motor encoder tracker
// Matches feedback frames to motors, unwraps multi-turn position and
// reports a moving-average speed for the matched motor.
// ----------------------------------------------------------------------------
// The block takes one frame per clock while the output is not stalled; each
// word passes the input register and then the result register. Throughput is
// one word per cycle without stalls, bounded by the per-motor state update,
// which reads and writes the matched motor's registers and its delta ring in
// the same cycle so that back-to-back frames of one motor chain correctly.
// Reset clears all but the input and result data registers; no clearing pass
// is run. Configuration writes are meant for idle periods only.
`include "assert_macros.svh"

module multi_motor_encoder_unwrap_speed (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mmeus_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmeus_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mmeus_in_if.sink                         in_i,
  mmeus_out_if.source                      out_o
);

  mmeus_pkg::cfg_t   cfg_q;
  mmeus_pkg::match_t mt;
  mmeus_pkg::track_t tr;

  logic                          in_v_q, res_v_q, res_v_d, adv;
  logic [mmeus_pkg::ID_W-1:0]    fid_q;
  logic [mmeus_pkg::ANGLE_W-1:0] ang_q;
  logic signed [mmeus_pkg::SPEED_W-1:0] speed;

  logic                                 res_matched_q, res_calib_q;
  logic [mmeus_pkg::MIDX_W-1:0]         res_idx_q;
  logic signed [mmeus_pkg::DELTA_W-1:0] res_delta_q;
  logic signed [mmeus_pkg::TURNS_W-1:0] res_turns_q;
  logic signed [mmeus_pkg::POS_W-1:0]   res_pos_q;
  logic signed [mmeus_pkg::SPEED_W-1:0] res_speed_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_id[0]  <= mmeus_pkg::MOTOR0_ID_RST;
      cfg_q.motor_id[1]  <= mmeus_pkg::MOTOR1_ID_RST;
      cfg_q.motor_id[2]  <= mmeus_pkg::MOTOR2_ID_RST;
      cfg_q.motor_id[3]  <= mmeus_pkg::MOTOR3_ID_RST;
      cfg_q.calib_frames <= mmeus_pkg::CALIB_FRAMES_RST;
      cfg_q.speed_gain   <= mmeus_pkg::SPEED_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmeus_pkg::REG_MOTOR0_ID:    cfg_q.motor_id[0]  <= cfg_data_i[mmeus_pkg::ID_W-1:0];
        mmeus_pkg::REG_MOTOR1_ID:    cfg_q.motor_id[1]  <= cfg_data_i[mmeus_pkg::ID_W-1:0];
        mmeus_pkg::REG_MOTOR2_ID:    cfg_q.motor_id[2]  <= cfg_data_i[mmeus_pkg::ID_W-1:0];
        mmeus_pkg::REG_MOTOR3_ID:    cfg_q.motor_id[3]  <= cfg_data_i[mmeus_pkg::ID_W-1:0];
        mmeus_pkg::REG_CALIB_FRAMES: cfg_q.calib_frames <= cfg_data_i[mmeus_pkg::CALIB_W-1:0];
        mmeus_pkg::REG_SPEED_GAIN:   cfg_q.speed_gain   <= cfg_data_i[mmeus_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Two-stage flow control: a word moves on whenever the result slot is
  // free or is being taken in the same cycle.
  assign adv        = in_v_q && (!res_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || adv;

  always_comb begin
    if (adv) begin
      res_v_d = 1'b1;
    end else if (out_o.ready) begin
      res_v_d = 1'b0;
    end else begin
      res_v_d = res_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_v_q <= in_i.valid;
      end
      res_v_q <= res_v_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      fid_q <= in_i.frame_id;
      ang_q <= in_i.angle;
    end
  end

  mmeus_match u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .cfg_i      (cfg_q),
    .frame_id_i (fid_q),
    .match_o    (mt)
  );

  mmeus_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .match_i (mt),
    .angle_i (ang_q),
    .track_o (tr)
  );

  mmeus_speed u_speed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .hit_i   (mt.hit),
    .idx_i   (mt.idx),
    .delta_i (tr.delta),
    .gain_i  (cfg_q.speed_gain),
    .speed_o (speed)
  );

  // Result register; an unmatched frame reports only the startup status.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_matched_q <= mt.hit;
      res_calib_q   <= mt.calib;
      res_idx_q     <= mt.hit ? mt.idx : '0;
      res_delta_q   <= mt.hit ? tr.delta : '0;
      res_turns_q   <= mt.hit ? tr.turns : '0;
      res_pos_q     <= mt.hit ? tr.position : '0;
      res_speed_q   <= mt.hit ? speed : '0;
    end
  end

  assign out_o.valid       = res_v_q;
  assign out_o.matched     = res_matched_q;
  assign out_o.motor_index = res_idx_q;
  assign out_o.calibrating = res_calib_q;
  assign out_o.delta       = res_delta_q;
  assign out_o.turns       = res_turns_q;
  assign out_o.position    = res_pos_q;
  assign out_o.speed       = res_speed_q;

  // Assertions.
  `MMEUS_ASSERT(a_unmatched_zero, (out_o.valid && !out_o.matched) |-> (out_o.motor_index == '0 && out_o.delta == '0 && out_o.turns == '0 && out_o.position == '0 && out_o.speed == '0), "unmatched result carries motor data")
  `MMEUS_ASSERT(a_delta_range, (out_o.valid && out_o.matched) |-> (out_o.delta >= -14'sd4096 && out_o.delta <= 14'sd4096), "unwrapped delta out of half-turn range")
  `MMEUS_ASSERT(a_count_clamped, adv |=> (mt.count <= $past(cfg_q.calib_frames)), "startup count above calibration length")
  `MMEUS_NEVER(a_stall_cause, !in_i.ready && !(in_v_q && res_v_q && !out_o.ready), "input stalled without a full pipeline")

endmodule
